/* rtl/efc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efc_pkg
// Shared types and constants of the Euler flux unit.
// ----------------------------------------------------------------------------
package efc_pkg;

  localparam int GAMMA_W = 18;
  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 18'd91750;
  localparam logic [GAMMA_W-1:0] GAMMA_ONE = 18'd65536;
  localparam int DEFAULT_SPACE_DIMS = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int APB_ADDR_W = 3;
  // Register index is taken from address bit 2.
  localparam logic REG_GAMMA = 1'b0;

  typedef struct packed {
    logic signed [31:0] density;
    logic signed [31:0] momentum_x;
    logic signed [31:0] momentum_y;
    logic signed [31:0] momentum_z;
    logic signed [31:0] total_energy;
  } state_in_t;

  typedef struct packed {
    logic [1:0]         direction;
    logic signed [31:0] mass_flux;
    logic signed [31:0] flux_momentum_x;
    logic signed [31:0] flux_momentum_y;
    logic signed [31:0] flux_momentum_z;
    logic signed [31:0] energy_flux;
    logic signed [31:0] pressure;
    logic [30:0]        sound_speed;
    logic               nonphysical;
    logic               last;
  } flux_out_t;

  // One classified state handed from the front to the back.
  typedef struct packed {
    logic [31:0]       rho;
    logic [2:0][31:0]  mom;
    logic [31:0]       energy;
    logic [30:0]       pres;
    logic [30:0]       sspeed;
    logic              bad;
  } qent_t;

  typedef enum logic [3:0] {
    F_IDLE, F_SQ, F_ACC, F_KDIV, F_KWAIT, F_PMUL, F_PCHK,
    F_CMUL, F_CDIV, F_CWAIT, F_SQRT, F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_MUL, B_DIV, B_WAIT, B_EMIT
  } back_state_t;

endpackage

/* rtl/efc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module efc_div #(
  parameter int DW = 64,
  parameter int RW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [RW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);
  localparam int CW = $clog2(DW + 1);

  logic [RW-1:0] rem;
  logic [RW-1:0] dvs;
  logic [DW-1:0] quo;
  logic [CW-1:0] count;
  logic [RW:0]   trial;
  logic          ge;

  assign trial = {rem, quo[DW-1]};
  assign ge = (trial >= {1'b0, dvs});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count <= CW'(DW);
      end else if (count != '0) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // The quotient register starts as the dividend and fills with quotient bits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (count != '0) begin
      rem <= ge ? RW'(trial - {1'b0, dvs}) : trial[RW-1:0];
      quo <= {quo[DW-2:0], ge};
    end
  end
endmodule

/* rtl/efc_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efc_fifo
// Short queue of classified states between the front and the back.
// ----------------------------------------------------------------------------
module efc_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  efc_pkg::qent_t    wdata,
  input  logic              pop,
  output efc_pkg::qent_t    rdata,
  output logic              full,
  output logic              empty
);
  import efc_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  qent_t         slots [QUEUE_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [NW-1:0] fill;

  assign full = (fill == NW'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end
endmodule

/* rtl/efc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efc_front
// Accepts a state, finds pressure and sound speed, and classifies it.
// ----------------------------------------------------------------------------
module efc_front #(
  parameter int SPACE_DIMS = efc_pkg::DEFAULT_SPACE_DIMS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  efc_pkg::state_in_t            cmd,
  input  logic [efc_pkg::GAMMA_W-1:0]   gamma,
  output logic                          busy,
  output logic                          push,
  output efc_pkg::qent_t                entry,
  input  logic                          full
);
  import efc_pkg::*;

  localparam int DIMS = (SPACE_DIMS < 1) ? 1 : ((SPACE_DIMS > 3) ? 3 : SPACE_DIMS);
  localparam logic [33:0] KIN_CLAMP = 34'h2_0000_0000;

  front_state_t state, state_next, acc_state;

  logic [1:0]        idx;
  logic [31:0]       rho;
  logic [2:0][31:0]  mom;
  logic [31:0]       energy;
  logic [63:0]       msq;
  logic [31:0]       uint;
  logic [30:0]       pres;
  logic [30:0]       sspeed;
  logic              bad;
  logic [63:0]       prod;
  logic [61:0]       rad;
  logic [30:0]       root;
  logic [32:0]       srem;
  logic [4:0]        scount;

  logic              accept;
  logic              bad0;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [31:0]       mom_abs;
  logic              div_start;
  logic              div_done;
  logic [65:0]       div_dividend;
  logic [32:0]       div_divisor;
  logic [65:0]       quo;
  logic [33:0]       kin;
  logic [34:0]       unet;
  logic              upos;
  logic              p_zero;
  logic              csat;
  logic [34:0]       sq_t;
  logic [34:0]       sq_trial;
  logic              sq_ge;

  assign busy = !((state == F_IDLE) || ((state == F_PUSH) && !full));
  assign accept = start && !busy;
  assign push = (state == F_PUSH) && !full;
  assign bad0 = ($signed(cmd.density) <= 0) || (gamma <= GAMMA_ONE);
  assign acc_state = bad0 ? F_PUSH : F_SQ;

  assign mom_abs = mom[idx][31] ? (32'd0 - mom[idx]) : mom[idx];

  always_comb begin
    case (state)
      F_SQ: begin
        mul_a = mom_abs;
        mul_b = mom_abs;
      end
      F_PMUL: begin
        mul_a = {14'd0, gamma - GAMMA_ONE};
        mul_b = uint;
      end
      F_CMUL: begin
        mul_a = {14'd0, gamma};
        mul_b = {1'b0, pres};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // One divider serves the kinetic energy and the sound speed radicand.
  assign div_start = (state == F_KDIV) || (state == F_CDIV);
  assign div_dividend = (state == F_KDIV) ? {2'b00, msq} : {1'b0, prod[48:0], 16'd0};
  assign div_divisor = (state == F_KDIV) ? {rho, 1'b0} : {1'b0, rho};

  efc_div #(.DW(66), .RW(33)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quo)
  );

  assign kin = (quo > 66'(KIN_CLAMP)) ? KIN_CLAMP : quo[33:0];
  assign unet = {{3{energy[31]}}, energy} - {1'b0, kin};
  assign upos = !unet[34] && (unet != '0);
  assign p_zero = (prod[63:16] == '0);
  assign csat = (quo[65:62] != '0);

  // Integer square root, two radicand bits per step.
  assign sq_t = {srem, rad[61:60]};
  assign sq_trial = {2'b00, root, 2'b01};
  assign sq_ge = (sq_t >= sq_trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (accept) begin
          state_next = acc_state;
        end
      end
      F_SQ: state_next = F_ACC;
      F_ACC: state_next = (idx == 2'(DIMS - 1)) ? F_KDIV : F_SQ;
      F_KDIV: state_next = F_KWAIT;
      F_KWAIT: begin
        if (div_done) begin
          state_next = upos ? F_PMUL : F_PUSH;
        end
      end
      F_PMUL: state_next = F_PCHK;
      F_PCHK: state_next = p_zero ? F_PUSH : F_CMUL;
      F_CMUL: state_next = F_CDIV;
      F_CDIV: state_next = F_CWAIT;
      F_CWAIT: begin
        if (div_done) begin
          state_next = csat ? F_PUSH : F_SQRT;
        end
      end
      F_SQRT: begin
        if (scount == 5'd1) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full) begin
          state_next = accept ? acc_state : F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rho <= cmd.density;
      mom[0] <= cmd.momentum_x;
      mom[1] <= (DIMS >= 2) ? cmd.momentum_y : '0;
      mom[2] <= (DIMS >= 3) ? cmd.momentum_z : '0;
      energy <= cmd.total_energy;
      msq <= '0;
      idx <= '0;
      bad <= bad0;
      pres <= '0;
      sspeed <= '0;
    end else begin
      case (state)
        F_ACC: begin
          msq <= msq + prod;
          idx <= idx + 1'b1;
        end
        F_KWAIT: begin
          if (div_done) begin
            uint <= unet[31:0];
            if (!upos) begin
              bad <= 1'b1;
            end
          end
        end
        F_PCHK: begin
          if (p_zero) begin
            bad <= 1'b1;
          end
          pres <= (prod[63:47] != '0) ? '1 : prod[46:16];
        end
        F_CWAIT: begin
          if (div_done) begin
            if (csat) begin
              sspeed <= '1;
            end
            rad <= quo[61:0];
            root <= '0;
            srem <= '0;
            scount <= 5'd31;
          end
        end
        F_SQRT: begin
          srem <= sq_ge ? 33'(sq_t - sq_trial) : sq_t[32:0];
          root <= {root[29:0], sq_ge};
          rad <= {rad[59:0], 2'b00};
          scount <= scount - 1'b1;
          if (scount == 5'd1) begin
            sspeed <= {root[29:0], sq_ge};
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    entry.rho = rho;
    entry.mom = mom;
    entry.energy = energy;
    entry.bad = bad;
    entry.pres = bad ? '0 : pres;
    entry.sspeed = bad ? '0 : sspeed;
  end
endmodule

/* rtl/efc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efc_back
// Turns a classified state into one flux column per direction, or one if bad.
// ----------------------------------------------------------------------------
module efc_back #(
  parameter int SPACE_DIMS = efc_pkg::DEFAULT_SPACE_DIMS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 empty,
  input  efc_pkg::qent_t       entry,
  output logic                 pop,
  output efc_pkg::flux_out_t   result,
  output logic                 result_valid
);
  import efc_pkg::*;

  localparam int DIMS = (SPACE_DIMS < 1) ? 1 : ((SPACE_DIMS > 3) ? 3 : SPACE_DIMS);

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  back_state_t state, state_next;

  qent_t              cur;
  logic [1:0]         d;
  logic [1:0]         j;
  logic signed [65:0] prod;
  logic               neg;
  logic [2:0][31:0]   flux;
  logic [31:0]        eflux;

  logic signed [32:0] ep;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic [65:0]        mag;
  logic               div_start;
  logic               div_done;
  logic [63:0]        quo;
  logic signed [65:0] qs;
  logic signed [65:0] qsum;
  logic               is_energy;
  logic               is_last;

  assign ep = $signed({cur.energy[31], cur.energy}) + $signed({2'b00, cur.pres});
  assign is_energy = (j == 2'(DIMS));
  assign mul_a = is_energy ? ep : $signed({cur.mom[j][31], cur.mom[j]});
  assign mul_b = $signed({cur.mom[d][31], cur.mom[d]});
  assign is_last = cur.bad || (d == 2'(DIMS - 1));

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Divide magnitudes so that the quotient truncates toward zero.
  assign mag = prod[65] ? (66'd0 - prod) : prod;
  assign div_start = (state == B_DIV);

  efc_div #(.DW(64), .RW(32)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag[63:0]),
    .divisor  (cur.rho),
    .done     (div_done),
    .quotient (quo)
  );

  assign qs = neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
  assign qsum = qs + ((j == d) ? $signed({35'd0, cur.pres}) : 66'sd0);
  assign pop = (state == B_IDLE) && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!empty) begin
          state_next = entry.bad ? B_EMIT : B_MUL;
        end
      end
      B_MUL: state_next = B_DIV;
      B_DIV: state_next = B_WAIT;
      B_WAIT: begin
        if (div_done) begin
          state_next = is_energy ? B_EMIT : B_MUL;
        end
      end
      B_EMIT: state_next = is_last ? B_IDLE : B_MUL;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!empty) begin
          cur <= entry;
          d <= '0;
          j <= '0;
          flux <= '0;
          eflux <= '0;
        end
      end
      B_DIV: neg <= prod[65];
      B_WAIT: begin
        if (div_done) begin
          if (is_energy) begin
            eflux <= sat32(qs);
          end else begin
            flux[j] <= sat32(qsum);
          end
          j <= j + 1'b1;
        end
      end
      B_EMIT: begin
        d <= d + 1'b1;
        j <= '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == B_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_EMIT) begin
      result.direction <= cur.bad ? 2'd0 : d;
      result.mass_flux <= cur.bad ? '0 : cur.mom[d];
      result.flux_momentum_x <= cur.bad ? '0 : flux[0];
      result.flux_momentum_y <= cur.bad ? '0 : flux[1];
      result.flux_momentum_z <= cur.bad ? '0 : flux[2];
      result.energy_flux <= cur.bad ? '0 : eflux;
      result.pressure <= {1'b0, cur.pres};
      result.sound_speed <= cur.sspeed;
      result.nonphysical <= cur.bad;
      result.last <= is_last;
    end
  end
endmodule

/* rtl/euler_flux_from_conserved_state_unit.sv */
`timescale 1ns / 1ps
// The front does two 66-bit divisions and a 31-step root per state. The back
// then does D*(D+1) 64-bit divisions on its serial divider, D = SPACE_DIMS;
// that divider limits the rate, and the back takes a new state only when idle.
// A bad state skips the divisions and gives a single transfer in the back.
// The front takes the next state while the back works. Results are never
// stalled. Synchronous reset clears control state; gamma resets to 1.4.
// ----------------------------------------------------------------------------
// euler_flux_from_conserved_state_unit
// Compressible Euler flux columns of one conserved gas state, Q16.16.
// ----------------------------------------------------------------------------
module euler_flux_from_conserved_state_unit #(
  parameter int SPACE_DIMS = efc_pkg::DEFAULT_SPACE_DIMS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  efc_pkg::state_in_t             cmd,
  output logic                           busy,
  output efc_pkg::flux_out_t             result,
  output logic                           result_valid,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [efc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import efc_pkg::*;

  localparam int DIMS = (SPACE_DIMS < 1) ? 1 : ((SPACE_DIMS > 3) ? 3 : SPACE_DIMS);

  logic [GAMMA_W-1:0] gamma;
  logic               push;
  logic               pop;
  logic               full;
  logic               empty;
  qent_t              wentry;
  qent_t              rentry;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_GAMMA) ? {14'd0, gamma} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma <= GAMMA_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_GAMMA)) begin
      gamma <= pwdata[GAMMA_W-1:0];
    end
  end

  efc_front #(.SPACE_DIMS(SPACE_DIMS)) u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .gamma (gamma),
    .busy  (busy),
    .push  (push),
    .entry (wentry),
    .full  (full)
  );

  efc_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wentry),
    .pop   (pop),
    .rdata (rentry),
    .full  (full),
    .empty (empty)
  );

  efc_back #(.SPACE_DIMS(SPACE_DIMS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .entry        (rentry),
    .pop          (pop),
    .result       (result),
    .result_valid (result_valid)
  );

  // A flagged state is always a single, final transfer.
  a_bad_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.nonphysical |-> result.last)
    else $error("nonphysical result without last");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.nonphysical |-> (result.pressure == 0) &&
      (result.sound_speed == 0) && (result.direction == 0))
    else $error("nonphysical result carries data");

  a_dir_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.direction <= 2'(DIMS - 1)))
    else $error("direction beyond dimension count");

  a_spaced: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("back-to-back result transfers");
endmodule
